[hw/rtl/top_k_sorted_insert_defines.svh]
// Assertion macros used by the checker file of this block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TOP_K_SORTED_INSERT_DEFINES_SVH
`define TOP_K_SORTED_INSERT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TKSI_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TKSI_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tksi_pkg.sv]
`default_nettype none

package tksi_pkg;

	localparam int unsigned CAPACITY_DEF = 64;

	localparam int unsigned ID_W     = 32;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned CNT_W    = 7;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned ENTRY_W  = ID_W + KEY_W;

	// Configuration register indexes and reset values.
	localparam logic CFG_KEEP_MODE  = 1'b0;
	localparam logic CFG_KEEP_COUNT = 1'b1;
	localparam logic             KEEP_MODE_RST  = 1'b1;
	localparam logic [CNT_W-1:0] KEEP_COUNT_RST = 7'd64;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED    = 3'd0,
		ST_REPLACED = 3'd1,
		ST_REJECTED = 3'd2,
		ST_DROPPED  = 3'd3,
		ST_READ_OK  = 3'd4,
		ST_BAD_POS  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		IDX_HOLD = 2'd0,
		IDX_FILL = 2'd1,
		IDX_LAST = 2'd2,
		IDX_DEC  = 2'd3
	} idx_op_t;

	typedef enum logic [1:0] {
		RA_POS  = 2'd0,
		RA_LAST = 2'd1,
		RA_IM1  = 2'd2,
		RA_IM2  = 2'd3
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		idx_op_t idx_op;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_zero;
		logic    wr_shift;
		logic    emit;
		status_t code;
		logic    fill_inc;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_read;
		logic pos_ok;
		logic full;
		logic mode_topk;
		logic fill_zero;
		logic ahead;
		logic i_zero;
		logic i_one;
	} sts_t;

endpackage

`default_nettype wire

[hw/rtl/tksi_ram.sv]
`default_nettype none

module tksi_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tksi_ctrl.sv]
`default_nettype none

module tksi_ctrl import tksi_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      busy
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_RDWAIT = 6'b000100,
		S_CHECK  = 6'b001000,
		S_SHIFT  = 6'b010000,
		S_PUT    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   add_q, add_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			add_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			add_q   <= add_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d      = state_q;
		add_d        = add_q;
		cmd          = '0;
		cmd.idx_op   = IDX_HOLD;
		cmd.rd_sel   = RA_POS;
		cmd.code     = ST_ADDED;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.op_read) begin
					if (sts.pos_ok) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RA_POS;
						state_d    = S_RDWAIT;
					end else begin
						cmd.emit = 1'b1;
						cmd.code = ST_BAD_POS;
						state_d  = S_IDLE;
					end
				end else if (!sts.full) begin
					if (sts.fill_zero) begin
						cmd.wr_en    = 1'b1;
						cmd.wr_zero  = 1'b1;
						cmd.fill_inc = 1'b1;
						cmd.emit     = 1'b1;
						cmd.code     = ST_ADDED;
						state_d      = S_IDLE;
					end else begin
						cmd.idx_op = IDX_FILL;
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RA_LAST;
						add_d      = 1'b1;
						state_d    = S_SHIFT;
					end
				end else if (!sts.mode_topk) begin
					cmd.emit = 1'b1;
					cmd.code = ST_DROPPED;
					state_d  = S_IDLE;
				end else begin
					cmd.idx_op = IDX_LAST;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_LAST;
					add_d      = 1'b0;
					state_d    = S_CHECK;
				end
			end
			S_RDWAIT: begin
				cmd.emit = 1'b1;
				cmd.code = ST_READ_OK;
				state_d  = S_IDLE;
			end
			S_CHECK: begin
				// The last entry is on the read port; a better item takes its slot.
				if (!sts.ahead) begin
					cmd.emit = 1'b1;
					cmd.code = ST_REJECTED;
					state_d  = S_IDLE;
				end else if (sts.i_zero) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_zero = 1'b1;
					cmd.emit    = 1'b1;
					cmd.code    = ST_REPLACED;
					state_d     = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IM1;
					state_d    = S_SHIFT;
				end
			end
			S_SHIFT: begin
				// Entry i-1 is on the read port. Either move it up or drop the item in at i.
				if (sts.ahead) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_shift = 1'b1;
					cmd.idx_op   = IDX_DEC;
					if (sts.i_one) begin
						state_d = S_PUT;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RA_IM2;
					end
				end else begin
					cmd.wr_en    = 1'b1;
					cmd.emit     = 1'b1;
					cmd.code     = add_q ? ST_ADDED : ST_REPLACED;
					cmd.fill_inc = add_q;
					state_d      = S_IDLE;
				end
			end
			S_PUT: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_zero  = 1'b1;
				cmd.emit     = 1'b1;
				cmd.code     = add_q ? ST_ADDED : ST_REPLACED;
				cmd.fill_inc = add_q;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/tksi_dp.sv]
`default_nettype none

module tksi_dp import tksi_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output sts_t                     sts,
	input  wire logic                operation,
	input  wire logic [ID_W-1:0]     id,
	input  wire logic [KEY_W-1:0]    key,
	input  wire logic [POS_W-1:0]    position,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [CNT_W-1:0]    cfg_data,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [ID_W-1:0]          entry_id,
	output logic [KEY_W-1:0]         entry_key,
	output logic [CNT_W-1:0]         count
);

	localparam int unsigned AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;

	logic               mode_q;
	logic [CNT_W-1:0]   keep_count_q;
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  fill_next;
	logic [FILL_W-1:0]  fill_m1;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      i_m1;
	logic [AW-1:0]      i_m2;

	logic               req_op_q;
	logic [ID_W-1:0]    req_id_q;
	logic [KEY_W-1:0]   req_key_q;
	logic [POS_W-1:0]   req_pos_q;

	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   fill_ext;
	logic [CMP_W-1:0]   kc_ext;
	logic [CMP_W-1:0]   fill_next_ext;

	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [ID_W-1:0]    rd_id;
	logic [KEY_W-1:0]   rd_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= KEEP_MODE_RST;
			keep_count_q <= KEEP_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEEP_MODE:  mode_q       <= cfg_data[0];
				CFG_KEEP_COUNT: keep_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_op_q  <= operation;
			req_id_q  <= id;
			req_key_q <= key;
			req_pos_q <= position;
		end
	end

	assign fill_m1   = fill_q - FILL_W'(1);
	assign i_m1      = i_q - AW'(1);
	assign i_m2      = i_m1 - AW'(1);
	assign fill_next = cmd.fill_inc ? (fill_q + FILL_W'(1)) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.idx_op)
			IDX_FILL: i_q <= fill_q[AW-1:0];
			IDX_LAST: i_q <= fill_m1[AW-1:0];
			IDX_DEC:  i_q <= i_m1;
			default:  i_q <= i_q;
		endcase
	end

	assign pos_ext       = CMP_W'(req_pos_q);
	assign fill_ext      = CMP_W'(fill_q);
	assign kc_ext        = CMP_W'(keep_count_q);
	assign fill_next_ext = CMP_W'(fill_next);

	always_comb begin
		case (cmd.rd_sel)
			RA_POS:  ram_raddr = pos_ext[AW-1:0];
			RA_LAST: ram_raddr = fill_m1[AW-1:0];
			RA_IM1:  ram_raddr = i_m1;
			default: ram_raddr = i_m2;
		endcase
	end

	assign ram_re    = cmd.rd_en;
	assign ram_waddr = cmd.wr_zero ? '0 : i_q;
	assign ram_wdata = cmd.wr_shift ? ram_rdata : {req_id_q, req_key_q};

	tksi_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_slot_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_id  = ram_rdata[ENTRY_W-1:KEY_W];
	assign rd_key = ram_rdata[KEY_W-1:0];

	always_comb begin
		sts.op_read   = req_op_q;
		sts.pos_ok    = (pos_ext < fill_ext);
		// A zero limit behaves as one; a limit above the capacity behaves as the capacity.
		if (keep_count_q == '0) begin
			sts.full = (fill_q != '0);
		end else begin
			sts.full = (fill_ext >= kc_ext) || (fill_q == FILL_W'(CAPACITY));
		end
		sts.mode_topk = mode_q;
		sts.fill_zero = (fill_q == '0);
		if (mode_q && (req_key_q != rd_key)) begin
			sts.ahead = (req_key_q > rd_key);
		end else begin
			sts.ahead = (req_id_q < rd_id);
		end
		sts.i_zero = (i_q == '0);
		sts.i_one  = (i_q == AW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status <= cmd.code;
			count  <= fill_next_ext[CNT_W-1:0];
			if (cmd.code == ST_READ_OK) begin
				entry_id  <= rd_id;
				entry_key <= rd_key;
			end else begin
				entry_id  <= '0;
				entry_key <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/top_k_sorted_insert.sv]
`default_nettype none

// Bounded sorted list of (id, key) entries held in one single-port-write RAM.
// Command channel: an item is taken at a clock edge with start high and busy low.
// operation 0 inserts (id, key); operation 1 reads the entry at position.
// Each item gives exactly one result, shown for one cycle while done is high:
// status, entry_id and entry_key (zero unless a read succeeds) and count, the
// number of entries held after the item. The receiver cannot stall results.
// A bad position, a drop or an insert into an empty list ends in the decide
// state; a read ends in the read-wait state, a rejection or a replacement in a
// one-entry list in the check state. An insert passes through the shift state,
// a replacement through the check and shift states, one shift per moved entry.
// The RAM moves one entry per cycle, so a better item that replaces the last
// entry of a full list and moves to the top sets the worst case. busy falls with
// the edge that raises done, and the next item can be taken in the done cycle.
// Configuration: cfg_index 0 is keep_mode, 1 is keep_count; cfg_ready is high
// whenever the block is not busy.
// Reset empties the list and loads keep_mode 1 and keep_count 64. The RAM is not
// cleared; only entries below the fill count are ever read.
module top_k_sorted_insert import tksi_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                operation,
	input  wire logic [ID_W-1:0]     id,
	input  wire logic [KEY_W-1:0]    key,
	input  wire logic [POS_W-1:0]    position,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [ID_W-1:0]          entry_id,
	output logic [KEY_W-1:0]         entry_key,
	output logic [CNT_W-1:0]         count,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [CNT_W-1:0]    cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic accept;

	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	tksi_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	tksi_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.operation(operation),
		.id       (id),
		.key      (key),
		.position (position),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.done     (done),
		.status   (status),
		.entry_id (entry_id),
		.entry_key(entry_key),
		.count    (count)
	);

endmodule

`default_nettype wire

[hw/rtl/tksi_checker.sv]
`default_nettype none

`include "top_k_sorted_insert_defines.svh"

module tksi_checker import tksi_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [ID_W-1:0]     entry_id,
	input wire logic [KEY_W-1:0]    entry_key,
	input wire logic [CNT_W-1:0]    count
);

	// A transaction taken on the command channel makes the block busy in the next cycle.
	`TKSI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
	`TKSI_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
	`TKSI_ASSERT_SAME(a_fall_done, $fell(busy), done, "busy fell without a result")
	`TKSI_ASSERT_SAME(a_zero_entry, done && (status != ST_READ_OK),
		(entry_id == '0) && (entry_key == '0), "entry fields not zero on a non-read result")
	`TKSI_ASSERT_SAME(a_read_count, done && (status == ST_READ_OK), count != '0,
		"successful read from an empty list")

endmodule

bind top_k_sorted_insert tksi_checker u_tksi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.status   (status),
	.entry_id (entry_id),
	.entry_key(entry_key),
	.count    (count)
);

`default_nettype wire

[test/tb.sv]
module tb;
	import tksi_pkg::*;

	localparam int SLOTS = CAPACITY_DEF;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct {
		status_t           code;
		logic [ID_W-1:0]   eid;
		logic [KEY_W-1:0]  ekey;
		logic [CNT_W-1:0]  cnt;
	} list_result_t;

	// Tracks the sorted list as the block should hold it and queues the
	// result that each accepted transaction should produce.
	class sorted_list_tracker;
		logic [ID_W-1:0]  slot_ids [SLOTS];
		logic [KEY_W-1:0] slot_keys [SLOTS];
		int fill = 0;
		bit by_key = KEEP_MODE_RST;
		logic [CNT_W-1:0] limit_reg = KEEP_COUNT_RST;
		list_result_t awaited_results [$];
		int mismatch_count = 0;

		function void write_reg(logic idx, logic [CNT_W-1:0] val);
			if (idx == CFG_KEEP_MODE)
				by_key = val[0];
			else
				limit_reg = val;
		endfunction

		function bit ranks_ahead(logic [ID_W-1:0] i, logic [KEY_W-1:0] k, int slot);
			if (by_key && k != slot_keys[slot])
				return k > slot_keys[slot];
			return i < slot_ids[slot];
		endfunction

		// Insertion step of a sorted list: shift lower-ranked entries down by one.
		function void place(logic [ID_W-1:0] i, logic [KEY_W-1:0] k, int n);
			int j;
			j = n;
			while (j > 0 && ranks_ahead(i, k, j - 1)) begin
				slot_ids[j] = slot_ids[j - 1];
				slot_keys[j] = slot_keys[j - 1];
				j--;
			end
			slot_ids[j] = i;
			slot_keys[j] = k;
		endfunction

		function void note_item(logic op, logic [ID_W-1:0] i, logic [KEY_W-1:0] k,
				logic [POS_W-1:0] p);
			list_result_t r;
			int lim;
			lim = int'(limit_reg);
			if (lim < 1)
				lim = 1;
			if (lim > SLOTS)
				lim = SLOTS;
			r.eid = '0;
			r.ekey = '0;
			if (op == OP_READ) begin
				if (p < fill) begin
					r.code = ST_READ_OK;
					r.eid = slot_ids[p];
					r.ekey = slot_keys[p];
				end else begin
					r.code = ST_BAD_POS;
				end
			end else if (fill < lim) begin
				place(i, k, fill);
				fill++;
				r.code = ST_ADDED;
			end else if (!by_key) begin
				r.code = ST_DROPPED;
			end else if (ranks_ahead(i, k, fill - 1)) begin
				// The last entry is evicted and the newcomer moves up to its place.
				place(i, k, fill - 1);
				r.code = ST_REPLACED;
			end else begin
				r.code = ST_REJECTED;
			end
			r.cnt = fill[CNT_W-1:0];
			awaited_results.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] eid,
				logic [KEY_W-1:0] ekey, logic [CNT_W-1:0] cnt);
			list_result_t e;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("mismatch: unexpected result status=%0d id=%h key=%h count=%0d",
						st, eid, ekey, cnt);
				return;
			end
			e = awaited_results.pop_front();
			if (st !== e.code || eid !== e.eid || ekey !== e.ekey || cnt !== e.cnt) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("mismatch: expected status=%0d id=%h key=%h count=%0d",
						e.code, e.eid, e.ekey, e.cnt);
					$display("          actual   status=%0d id=%h key=%h count=%0d",
						st, eid, ekey, cnt);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic operation = OP_INSERT;
	logic [ID_W-1:0] id = '0;
	logic [KEY_W-1:0] key = '0;
	logic [POS_W-1:0] position = '0;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0] entry_id;
	logic [KEY_W-1:0] entry_key;
	logic [CNT_W-1:0] count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_KEEP_MODE;
	logic [CNT_W-1:0] cfg_data = '0;

	sorted_list_tracker tracker = new();

	top_k_sorted_insert DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.id(id),
		.key(key),
		.position(position),
		.done(done),
		.status(status),
		.entry_id(entry_id),
		.entry_key(entry_key),
		.count(count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("tb: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_result(status, entry_id, entry_key, count);
			if (start && !busy)
				tracker.note_item(operation, id, key, position);
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
		end
	end

	task automatic send_item(input logic op, input logic [ID_W-1:0] i,
			input logic [KEY_W-1:0] k, input logic [POS_W-1:0] p);
		operation <= op;
		id <= i;
		key <= k;
		position <= p;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Every transaction yields one result, so an empty queue means the block is idle.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic mode, input logic [CNT_W-1:0] limit);
		cfg_index <= CFG_KEEP_MODE;
		cfg_data <= {{(CNT_W-1){1'b0}}, mode};
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_index <= CFG_KEEP_COUNT;
		cfg_data <= limit;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		bit seg_mode [7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		int seg_limit [7] = '{20, 30, 1, 127, 64, 10, 127};
		int seg_len [7] = '{60, 50, 40, 80, 90, 30, 100};
		bit idle_on;
		logic op;
		logic [ID_W-1:0] rid;
		logic [KEY_W-1:0] rkey;
		logic [POS_W-1:0] rpos;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: best by key, full capacity.
		send_item(OP_READ, '0, '0, 6'd0);
		send_item(OP_READ, '0, '0, 6'd63);
		send_item(OP_INSERT, 32'd5, 32'd100, '0);
		send_item(OP_READ, '0, '0, 6'd0);
		send_item(OP_READ, '0, '0, 6'd1);

		// A zero limit behaves as one, so the single entry is always the last one.
		drain_results();
		write_cfg(1'b1, 7'd0);
		send_item(OP_INSERT, 32'd3, 32'd100, '0);
		send_item(OP_INSERT, 32'd3, 32'd100, '0);
		send_item(OP_INSERT, 32'd0, 32'd0, '0);
		send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		send_item(OP_READ, '0, '0, 6'd0);

		drain_results();
		write_cfg(1'b1, 7'd4);
		send_item(OP_INSERT, 32'd7, 32'd50, '0);
		send_item(OP_INSERT, 32'd2, 32'd50, '0);
		send_item(OP_INSERT, 32'd9, 32'hFFFF_FFFF, '0);
		send_item(OP_INSERT, 32'd1, 32'd10, '0);
		send_item(OP_INSERT, 32'd4, 32'd50, '0);
		send_item(OP_READ, '0, '0, 6'd3);

		// Switch to id order on a list sorted by key; equal ids land after the old one.
		drain_results();
		write_cfg(1'b0, 7'd6);
		send_item(OP_INSERT, 32'd7, 32'd1, '0);
		send_item(OP_INSERT, 32'd0, 32'd2, '0);
		send_item(OP_INSERT, 32'd8, 32'd3, '0);
		send_item(OP_READ, '0, '0, 6'd0);
		send_item(OP_READ, '0, '0, 6'd5);
		send_item(OP_READ, '0, '0, 6'd6);

		for (int seg = 0; seg < 7; seg++) begin
			drain_results();
			write_cfg(seg_mode[seg], seg_limit[seg][CNT_W-1:0]);
			idle_on = (seg != 6);
			for (int n = 0; n < seg_len[seg]; n++) begin
				op = ($urandom_range(0, 9) < 3) ? OP_READ : OP_INSERT;
				// Narrow ranges make equal ids and equal keys common.
				case ($urandom_range(0, 3))
					0: rid = $urandom_range(0, 15);
					1: rid = 32'hFFFF_FFFF - $urandom_range(0, 15);
					default: rid = $urandom;
				endcase
				case ($urandom_range(0, 3))
					0: rkey = $urandom_range(0, 7);
					1: rkey = 32'hFFFF_FFFF - $urandom_range(0, 7);
					default: rkey = $urandom;
				endcase
				if ($urandom_range(0, 1))
					rpos = POS_W'($urandom_range(0, 63));
				else
					rpos = POS_W'($urandom_range(0, (tracker.fill < 63) ? tracker.fill : 63));
				send_item(op, rid, rkey, rpos);
				if (idle_on && $urandom_range(0, 4) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 19)) @(posedge clk);
				end
			end
		end

		drain_results();
		repeat (SLOTS + 8) @(posedge clk);
		tracker.mismatch_count += tracker.awaited_results.size();
		if (tracker.mismatch_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
